// ----- src/tlv_packet_validator_defines.svh -----
// ----------------------------------------------------------------------------
// tlv_packet_validator_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef TLV_PACKET_VALIDATOR_DEFINES_SVH
`define TLV_PACKET_VALIDATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TLVPV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TLVPV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tlvpv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvpv_pkg
// types, codes and sizes shared by the tlv packet validator modules
// ----------------------------------------------------------------------------
package tlvpv_pkg;

    localparam int MAX_PACKET = 1024;
    localparam int CNT_W      = $clog2(MAX_PACKET + 2);
    localparam int LEN_W      = 17;
    localparam int ADDR_W     = 3;
    localparam int OUT_W      = 24;

    localparam logic [CNT_W-1:0] CNT_MAX      = CNT_W'(MAX_PACKET + 1);
    localparam logic [LEN_W-1:0] HDR_LEN      = LEN_W'(4);
    localparam logic [LEN_W-1:0] ITEM_OVHD    = LEN_W'(2);
    localparam logic [LEN_W-1:0] MAX_PKT_LEN  = LEN_W'(MAX_PACKET);

    localparam logic [7:0] MAGIC_RESET   = 8'd95;
    localparam logic [7:0] VERSION_RESET = 8'd1;

    // register select by paddr[2]
    localparam logic REG_MAGIC   = 1'b0;
    localparam logic REG_VERSION = 1'b1;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_BAD_MAGIC   = 3'd1;
    localparam t_status ST_BAD_VERSION = 3'd2;
    localparam t_status ST_BAD_PKT_LEN = 3'd3;
    localparam t_status ST_BAD_ITEMS   = 3'd4;

    typedef struct packed {
        logic [7:0] magic_value;
        logic [7:0] version_value;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] len_field;
        t_status     status;
    } t_result;

endpackage

// ----- src/tlvpv_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvpv_cfg_regs
// apb register file holding the magic and version values
// ----------------------------------------------------------------------------
module tlvpv_cfg_regs
    import tlvpv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [7:0] r_magic;
    logic [7:0] r_version;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= MAGIC_RESET;
            r_version <= VERSION_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_MAGIC:   r_magic   <= pwdata[7:0];
                REG_VERSION: r_version <= pwdata[7:0];
                default:     r_magic   <= r_magic;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MAGIC:   prdata = {24'd0, r_magic};
            REG_VERSION: prdata = {24'd0, r_version};
            default:     prdata = 32'd0;
        endcase
    end

    assign o_cfg.magic_value   = r_magic;
    assign o_cfg.version_value = r_version;

endmodule

// ----- src/tlvpv_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvpv_in_stage
// input register and flow control toward the checker
// ----------------------------------------------------------------------------
module tlvpv_in_stage
    import tlvpv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_out_free,
    output logic     o_fire,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    // a last byte needs room in the output register
    assign o_fire  = r_valid & (~r_item.last_byte | i_out_free);
    assign o_ready = ~r_valid | o_fire;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- src/tlvpv_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvpv_check
// per-packet header tracking, item walk and status decision
// ----------------------------------------------------------------------------
module tlvpv_check
    import tlvpv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output t_result  o_result
);

    logic [CNT_W-1:0] r_cnt;
    logic             r_magic_bad;
    logic             r_version_bad;
    logic [15:0]      r_dl;
    logic [LEN_W-1:0] r_nis;

    logic [CNT_W-1:0] n_cnt;
    logic             n_magic_bad;
    logic             n_version_bad;
    logic [15:0]      n_dl;
    logic [LEN_W-1:0] n_nis;

    logic [LEN_W-1:0] idx_ext;
    logic [LEN_W-1:0] cur_end;
    logic             ver_final;
    logic [LEN_W-1:0] pkt_len;
    logic [LEN_W-1:0] pos;
    t_status          status;

    always_comb begin
        n_magic_bad   = r_magic_bad;
        n_version_bad = r_version_bad;
        n_dl          = r_dl;
        n_nis         = r_nis;
        idx_ext       = LEN_W'(r_cnt);
        cur_end       = LEN_W'(r_dl) + HDR_LEN;

        priority if (r_cnt == CNT_W'(0)) begin
            n_magic_bad = (i_item.data_byte != i_cfg.magic_value);
        end else if (r_cnt == CNT_W'(1)) begin
            n_version_bad = (i_item.data_byte != i_cfg.version_value);
        end else if (r_cnt == CNT_W'(2)) begin
            n_dl = {i_item.data_byte, r_dl[7:0]};
        end else if (r_cnt == CNT_W'(3)) begin
            n_dl = {r_dl[15:8], i_item.data_byte};
        end else if ((idx_ext == r_nis + LEN_W'(1)) && (r_nis < cur_end)) begin
            n_nis = r_nis + LEN_W'(i_item.data_byte) + ITEM_OVHD;
        end

        n_cnt = (r_cnt < CNT_MAX) ? r_cnt + CNT_W'(1) : r_cnt;

        // one-byte packet: version byte missing, reads as zero
        ver_final = (r_cnt == CNT_W'(0)) ? (i_cfg.version_value != 8'd0) : n_version_bad;

        pkt_len = LEN_W'(n_dl) + HDR_LEN;
        // item starting on the final byte reads a zero length
        pos     = (n_nis < pkt_len) ? n_nis + ITEM_OVHD : n_nis;

        priority if (n_magic_bad) begin
            status = ST_BAD_MAGIC;
        end else if (ver_final) begin
            status = ST_BAD_VERSION;
        end else if ((pkt_len != LEN_W'(n_cnt)) || (pkt_len > MAX_PKT_LEN)) begin
            status = ST_BAD_PKT_LEN;
        end else if (pos != pkt_len) begin
            status = ST_BAD_ITEMS;
        end else begin
            status = ST_OK;
        end
    end

    assign o_result.status    = status;
    assign o_result.len_field = n_dl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt         <= '0;
            r_magic_bad   <= 1'b0;
            r_version_bad <= 1'b0;
            r_dl          <= '0;
            r_nis         <= HDR_LEN;
        end else if (i_fire) begin
            if (i_item.last_byte) begin
                r_cnt         <= '0;
                r_magic_bad   <= 1'b0;
                r_version_bad <= 1'b0;
                r_dl          <= '0;
                r_nis         <= HDR_LEN;
            end else begin
                r_cnt         <= n_cnt;
                r_magic_bad   <= n_magic_bad;
                r_version_bad <= n_version_bad;
                r_dl          <= n_dl;
                r_nis         <= n_nis;
            end
        end
    end

endmodule

// ----- src/tlvpv_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvpv_out_stage
// result register on the master stream side
// ----------------------------------------------------------------------------
module tlvpv_out_stage
    import tlvpv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_result          i_result,
    output logic             o_free,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata
);

    logic    r_valid;
    t_result r_result;

    assign o_free        = ~r_valid | m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = OUT_W'(r_result);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- src/tlv_packet_validator.sv -----
`timescale 1ns / 1ps
// status is registered as a packet's last byte leaves the input register
// throughput: one byte per cycle, set by the single check stage between the
//   input and result registers; a last byte waits while the result is held
// reset: magic returns to 95, version to 1, and all packet tracking is cleared
// ----------------------------------------------------------------------------
// tlv_packet_validator
// checks header, body length and tlv item walk of each received datagram
// ----------------------------------------------------------------------------
module tlv_packet_validator
    import tlvpv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // [2:0] status, [18:3] len_field
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg     cfg;
    t_in_item in_item;
    t_in_item stage_item;
    t_result  result;
    logic     fire;
    logic     out_free;

    assign in_item.data_byte = s_axis_tdata;
    assign in_item.last_byte = s_axis_tlast;

    tlvpv_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tlvpv_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_item     (in_item),
        .i_out_free (out_free),
        .o_fire     (fire),
        .o_item     (stage_item)
    );

    tlvpv_check u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (stage_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    tlvpv_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (fire & stage_item.last_byte),
        .i_result      (result),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- src/tlvpv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvpv_checker
// port-level checks on the tlv packet validator, bound to the top level
// ----------------------------------------------------------------------------
`include "tlv_packet_validator_defines.svh"

module tlvpv_checker
    import tlvpv_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             s_axis_tlast,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    `TLVPV_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")
    `TLVPV_ASSERT_NOW(a_status_range, m_axis_tvalid, m_axis_tdata[2:0] <= ST_BAD_ITEMS,
        "status code out of range")
    `TLVPV_ASSERT_NOW(a_rose_from_last, $rose(m_axis_tvalid),
        $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2),
        "result without a last byte two cycles before")
    `TLVPV_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready,
        "input stalled with empty output register")

endmodule

bind tlv_packet_validator tlvpv_checker u_tlvpv_checker (.*);
